[src/scc_pkg.sv]
package scc_pkg;

   // Field widths of the request and of the radius.
   localparam int POS_W = 18;
   localparam int VEL_W = 14;
   localparam int RAD_W = 11;

   // Internal widths, sized to the largest value each quantity can reach.
   localparam int DP_W    = 19;   // relative position
   localparam int DV_W    = 15;   // relative velocity
   localparam int DE_W    = 20;   // end point of the relative path
   localparam int D2_W    = 24;   // squared contact distance
   localparam int W_W     = 30;   // squared speed
   localparam int PV_W    = 35;   // dot and cross products
   localparam int ACR_W   = 34;   // magnitude of the cross product
   localparam int SQ_IN_W = 27;   // cross products at or above 2^27 always miss
   localparam int PP_W    = 38;   // squared distance at the start
   localparam int EE_W    = 41;   // squared distance at the end
   localparam int LIM_W   = 54;   // D^2 * |v|^2
   localparam int D_W     = 54;   // discriminant
   localparam int A_W     = 35;   // |p.v|

   // Configuration port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [RAD_W-1:0] RADIUS_RESET = 11'd400;
   localparam logic [D2_W-1:0]  D2_RESET     = 24'd640000;

   // What travels with each request down the pipeline.
   typedef struct packed {
      logic           valid;
      logic           hit;
      logic           zero_time;
      logic [A_W-1:0] a;
      logic [W_W-1:0] w;
   } scc_job_type;

endpackage

[src/scc_csr.sv]
module scc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [scc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [scc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [scc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic [scc_pkg::D2_W-1:0]         d2
);
   import scc_pkg::*;

   logic [RAD_W-1:0] radius_ff, radius_in;
   logic [D2_W-1:0]  d2_ff, d2_in;
   logic [RAD_W:0]   diam;
   logic             wr_en;

   // Radius register only; addresses with top bit set are ignored.
   assign wr_en = psel & penable & pwrite & ~paddr[CSR_ADDR_W-1];
   assign diam  = {pwdata[RAD_W-1:0], 1'b0};

   // The squared contact distance is kept alongside the radius.
   always_comb begin
      radius_in = radius_ff;
      d2_in     = d2_ff;
      if (wr_en) begin
         radius_in = pwdata[RAD_W-1:0];
         d2_in     = D2_W'(diam) * D2_W'(diam);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         d2_ff     <= D2_RESET;
      end else begin
         radius_ff <= radius_in;
         d2_ff     <= d2_in;
      end
   end

   assign prdata = paddr[CSR_ADDR_W-1] ? '0 : CSR_DATA_W'(radius_ff);
   assign d2     = d2_ff;

endmodule

[src/scc_geom.sv]
module scc_geom (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic signed [scc_pkg::POS_W-1:0]    first_pos_x,
   input  logic signed [scc_pkg::POS_W-1:0]    first_pos_y,
   input  logic signed [scc_pkg::VEL_W-1:0]    first_vel_x,
   input  logic signed [scc_pkg::VEL_W-1:0]    first_vel_y,
   input  logic signed [scc_pkg::POS_W-1:0]    second_pos_x,
   input  logic signed [scc_pkg::POS_W-1:0]    second_pos_y,
   input  logic signed [scc_pkg::VEL_W-1:0]    second_vel_x,
   input  logic signed [scc_pkg::VEL_W-1:0]    second_vel_y,
   input  logic [scc_pkg::D2_W-1:0]            d2,
   output scc_pkg::scc_job_type                job,
   output logic [scc_pkg::D_W-1:0]             disc
);
   import scc_pkg::*;

   // Stage 1: relative position and velocity.
   logic                   s1_valid_ff;
   logic signed [DP_W-1:0] px_ff, py_ff, px_in, py_in;
   logic signed [DV_W-1:0] vx_ff, vy_ff, vx_in, vy_in;

   assign px_in = DP_W'(second_pos_x) - DP_W'(first_pos_x);
   assign py_in = DP_W'(second_pos_y) - DP_W'(first_pos_y);
   assign vx_in = DV_W'(second_vel_x) - DV_W'(first_vel_x);
   assign vy_in = DV_W'(second_vel_y) - DV_W'(first_vel_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_valid;
      end
      px_ff <= px_in;
      py_ff <= py_in;
      vx_ff <= vx_in;
      vy_ff <= vy_in;
   end

   // Stage 2: end point of the path, squares and cross-term products.
   logic                          s2_valid_ff;
   logic signed [DE_W-1:0]        ex, ey;
   logic signed [2*DV_W-1:0]      vxx_ff, vyy_ff, vxx_in, vyy_in;
   logic signed [DP_W+DV_W-1:0]   pxvx_ff, pyvy_ff, pxvy_ff, pyvx_ff;
   logic signed [DP_W+DV_W-1:0]   pxvx_in, pyvy_in, pxvy_in, pyvx_in;
   logic signed [2*DP_W-1:0]      pxx_ff, pyy_ff, pxx_in, pyy_in;
   logic signed [2*DE_W-1:0]      exx_ff, eyy_ff, exx_in, eyy_in;

   assign ex      = DE_W'(px_ff) + DE_W'(vx_ff);
   assign ey      = DE_W'(py_ff) + DE_W'(vy_ff);
   assign vxx_in  = (2*DV_W)'(vx_ff) * (2*DV_W)'(vx_ff);
   assign vyy_in  = (2*DV_W)'(vy_ff) * (2*DV_W)'(vy_ff);
   assign pxvx_in = (DP_W+DV_W)'(px_ff) * (DP_W+DV_W)'(vx_ff);
   assign pyvy_in = (DP_W+DV_W)'(py_ff) * (DP_W+DV_W)'(vy_ff);
   assign pxvy_in = (DP_W+DV_W)'(px_ff) * (DP_W+DV_W)'(vy_ff);
   assign pyvx_in = (DP_W+DV_W)'(py_ff) * (DP_W+DV_W)'(vx_ff);
   assign pxx_in  = (2*DP_W)'(px_ff) * (2*DP_W)'(px_ff);
   assign pyy_in  = (2*DP_W)'(py_ff) * (2*DP_W)'(py_ff);
   assign exx_in  = (2*DE_W)'(ex) * (2*DE_W)'(ex);
   assign eyy_in  = (2*DE_W)'(ey) * (2*DE_W)'(ey);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      vxx_ff  <= vxx_in;
      vyy_ff  <= vyy_in;
      pxvx_ff <= pxvx_in;
      pyvy_ff <= pyvy_in;
      pxvy_ff <= pxvy_in;
      pyvx_ff <= pyvx_in;
      pxx_ff  <= pxx_in;
      pyy_ff  <= pyy_in;
      exx_ff  <= exx_in;
      eyy_ff  <= eyy_in;
   end

   // Stage 3: squared speed, dot and cross products, squared distances.
   logic                   s3_valid_ff;
   logic [W_W-1:0]         w3_ff, w3_in;
   logic signed [PV_W-1:0] pv3_ff, pv3_in, cr_ff, cr_in;
   logic [PP_W-1:0]        pp3_ff, pp3_in;
   logic [EE_W-1:0]        ee3_ff, ee3_in;

   assign w3_in  = W_W'(vxx_ff) + W_W'(vyy_ff);
   assign pv3_in = PV_W'(pxvx_ff) + PV_W'(pyvy_ff);
   assign cr_in  = PV_W'(pxvy_ff) - PV_W'(pyvx_ff);
   assign pp3_in = PP_W'(pxx_ff) + PP_W'(pyy_ff);
   assign ee3_in = EE_W'(exx_ff) + EE_W'(eyy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      w3_ff  <= w3_in;
      pv3_ff <= pv3_in;
      cr_ff  <= cr_in;
      pp3_ff <= pp3_in;
      ee3_ff <= ee3_in;
   end

   // Stage 4: contact limit D^2*w and the squared cross product.
   logic                   s4_valid_ff;
   logic [ACR_W-1:0]       acr;
   logic                   big_ff, big_in;
   logic [LIM_W-1:0]       lim_ff, lim_in, acr_sq_ff, acr_sq_in;
   logic [W_W-1:0]         w4_ff;
   logic signed [PV_W-1:0] pv4_ff;
   logic [PP_W-1:0]        pp4_ff;
   logic [EE_W-1:0]        ee4_ff;

   assign acr       = cr_ff[PV_W-1] ? ACR_W'(-cr_ff) : ACR_W'(cr_ff);
   assign big_in    = |acr[ACR_W-1:SQ_IN_W];
   assign lim_in    = LIM_W'(d2) * LIM_W'(w3_ff);
   assign acr_sq_in = LIM_W'(acr[SQ_IN_W-1:0]) * LIM_W'(acr[SQ_IN_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      big_ff    <= big_in;
      lim_ff    <= lim_in;
      acr_sq_ff <= acr_sq_in;
      w4_ff     <= w3_ff;
      pv4_ff    <= pv3_ff;
      pp4_ff    <= pp3_ff;
      ee4_ff    <= ee3_ff;
   end

   // Stage 5: nearest point of the path, overlap and touch cases.
   logic signed [PV_W:0] pvw;
   logic                 pv_neg, pv_pos, near, pp_lt, pp_eq, go;
   scc_job_type          job_ff, job_in;
   logic [D_W-1:0]       disc_ff, disc_in;

   assign pvw    = (PV_W+1)'(pv4_ff) + (PV_W+1)'($signed({1'b0, w4_ff}));
   assign pv_neg = pv4_ff[PV_W-1];
   assign pv_pos = ~pv_neg & (|pv4_ff);
   assign pp_lt  = pp4_ff < PP_W'(d2);
   assign pp_eq  = pp4_ff == PP_W'(d2);

   always_comb begin
      if (pvw[PV_W]) begin
         near = ee4_ff <= EE_W'(d2);
      end else if (pv_pos) begin
         near = pp4_ff <= PP_W'(d2);
      end else begin
         near = acr_sq_ff <= lim_ff;
      end
   end

   // Overlapping circles that move apart do not count.
   assign go = (|w4_ff) & ~big_ff & near & ~(pp_lt & ~pv_neg);

   always_comb begin
      job_in.valid     = s4_valid_ff;
      job_in.hit       = go;
      job_in.zero_time = pp_lt | pp_eq;
      job_in.a         = pv_neg ? A_W'(-pv4_ff) : A_W'(pv4_ff);
      job_in.w         = w4_ff;
      disc_in          = (acr_sq_ff > lim_ff) ? '0 : D_W'(lim_ff - acr_sq_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff.valid <= 1'b0;
      end else begin
         job_ff <= job_in;
      end
      disc_ff <= disc_in;
   end

   assign job  = job_ff;
   assign disc = disc_ff;

endmodule

[src/scc_sqrt.sv]
module scc_sqrt #(
   parameter int FRAC = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  scc_pkg::scc_job_type                     job_i,
   input  logic [scc_pkg::D_W-1:0]                  disc_i,
   output scc_pkg::scc_job_type                     job_o,
   output logic [scc_pkg::D_W/2+FRAC-1:0]           root_o,
   output logic                                     rem_nz_o
);
   import scc_pkg::*;

   localparam int RB    = D_W/2 + FRAC;   // root bits, one per stage
   localparam int ARG_W = 2*RB;           // disc scaled by 2^(2*FRAC)
   localparam int RM_W  = RB + 2;         // remainder never exceeds 2*root

   scc_job_type      job_ff  [0:RB-1];
   scc_job_type      job_in  [0:RB-1];
   logic [RB-1:0]    root_ff [0:RB-1];
   logic [RB-1:0]    root_in [0:RB-1];
   logic [RM_W-1:0]  rem_ff  [0:RB-1];
   logic [RM_W-1:0]  rem_in  [0:RB-1];
   logic [ARG_W-1:0] arg_ff  [0:RB-1];
   logic [ARG_W-1:0] arg_in  [0:RB-1];

   // Digit-by-digit square root, one root bit per stage.
   for (genvar i = 0; i < RB; i++) begin : g_stage
      scc_job_type      job_cur;
      logic [RB-1:0]    root_cur;
      logic [RM_W-1:0]  rem_cur;
      logic [ARG_W-1:0] arg_cur;
      logic [RM_W+1:0]  rem_cat, trial;
      logic             take;

      if (i == 0) begin : g_first
         assign job_cur  = job_i;
         assign root_cur = '0;
         assign rem_cur  = '0;
         assign arg_cur  = {disc_i, {(2*FRAC){1'b0}}};
      end else begin : g_next
         assign job_cur  = job_ff[i-1];
         assign root_cur = root_ff[i-1];
         assign rem_cur  = rem_ff[i-1];
         assign arg_cur  = arg_ff[i-1];
      end

      // Bring down the next two bits and try the trial divisor 4*root+1.
      assign rem_cat    = {rem_cur, arg_cur[ARG_W-1 -: 2]};
      assign trial      = {2'b00, root_cur, 2'b01};
      assign take       = rem_cat >= trial;
      assign root_in[i] = {root_cur[RB-2:0], take};
      assign rem_in[i]  = take ? RM_W'(rem_cat - trial) : RM_W'(rem_cat);
      assign arg_in[i]  = {arg_cur[ARG_W-3:0], 2'b00};
      assign job_in[i]  = job_cur;

      always_ff @(posedge clock) begin
         if (reset) begin
            job_ff[i].valid <= 1'b0;
         end else begin
            job_ff[i] <= job_in[i];
         end
         root_ff[i] <= root_in[i];
         rem_ff[i]  <= rem_in[i];
         arg_ff[i]  <= arg_in[i];
      end
   end

   assign job_o    = job_ff[RB-1];
   assign root_o   = root_ff[RB-1];
   assign rem_nz_o = |rem_ff[RB-1];

endmodule

[src/scc_div.sv]
module scc_div #(
   parameter int FRAC = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  scc_pkg::scc_job_type             job_i,
   input  logic [scc_pkg::D_W/2+FRAC-1:0]   root_i,
   input  logic                             rem_nz_i,
   output logic                             rsp_valid,
   output logic                             rsp_hit,
   output logic [FRAC:0]                    rsp_hit_time
);
   import scc_pkg::*;

   localparam int N_W = A_W + FRAC;
   localparam int QB  = FRAC + 1;

   // Numerator 2^FRAC*|p.v| minus the rounded-up scaled square root.
   scc_job_type    prep_job_ff;
   logic [N_W-1:0] prep_n_ff, prep_n_in;

   assign prep_n_in = {job_i.a, {FRAC{1'b0}}} - N_W'(root_i) - N_W'(rem_nz_i);

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_job_ff.valid <= 1'b0;
      end else begin
         prep_job_ff <= job_i;
      end
      prep_n_ff <= prep_n_in;
   end

   scc_job_type    job_ff [0:QB-1];
   logic [N_W-1:0] n_ff   [0:QB-1];
   logic [N_W-1:0] n_in   [0:QB-1];
   logic [QB-1:0]  q_ff   [0:QB-1];
   logic [QB-1:0]  q_in   [0:QB-1];

   // Restoring division by |v|^2, one quotient bit per stage, top bit first.
   for (genvar j = 0; j < QB; j++) begin : g_step
      scc_job_type    job_cur;
      logic [N_W-1:0] n_cur, ws;
      logic [QB-1:0]  q_cur;
      logic           take;

      if (j == 0) begin : g_first
         assign job_cur = prep_job_ff;
         assign n_cur   = prep_n_ff;
         assign q_cur   = '0;
      end else begin : g_next
         assign job_cur = job_ff[j-1];
         assign n_cur   = n_ff[j-1];
         assign q_cur   = q_ff[j-1];
      end

      assign ws      = N_W'(job_cur.w) << (FRAC - j);
      assign take    = n_cur >= ws;
      assign n_in[j] = take ? N_W'(n_cur - ws) : n_cur;
      assign q_in[j] = {q_cur[QB-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            job_ff[j].valid <= 1'b0;
         end else begin
            job_ff[j] <= job_cur;
         end
         n_ff[j] <= n_in[j];
         q_ff[j] <= q_in[j];
      end
   end

   // Result register: a miss reports time zero, so does a touch or overlap.
   scc_job_type   last;
   logic          valid_ff, hit_ff, valid_in, hit_in;
   logic [FRAC:0] time_ff, time_in;

   assign last     = job_ff[QB-1];
   assign valid_in = last.valid;
   assign hit_in   = last.valid & last.hit;
   assign time_in  = (last.hit & ~last.zero_time) ? q_ff[QB-1] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      hit_ff  <= hit_in;
      time_ff <= time_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_hit      = hit_ff;
   assign rsp_hit_time = time_ff;

endmodule

[src/swept_circle_collision_time_top.sv]
// Swept-circle contact test for two equal circles over one time unit.
// Requests: drive the two positions and velocities on the req_ ports and
// raise start; a request is taken at every edge with start high, since busy
// stays low. A new request may be given in every cycle.
// Results: rsp_valid is high for one cycle per request, in request order,
// with rsp_hit and rsp_hit_time (unsigned, TIME_FRAC_BITS fraction bits).
// The receiver must take each result in that cycle; there is no back pressure.
// The result passes through the geometry stages, then the square root, which
// produces one root bit per stage, and the division, one quotient bit per
// stage, and is registered once more before rsp_valid rises.
// Throughput: one request per cycle.
// Configuration: collision_radius at byte address 0 of the APB port; write it
// only while no request is in flight. Reset clears the pipeline (requests in
// flight are dropped) and sets the radius to 400.
module swept_circle_collision_time_top #(
   parameter int TIME_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [scc_pkg::POS_W-1:0]     req_first_pos_x,
   input  logic signed [scc_pkg::POS_W-1:0]     req_first_pos_y,
   input  logic signed [scc_pkg::VEL_W-1:0]     req_first_vel_x,
   input  logic signed [scc_pkg::VEL_W-1:0]     req_first_vel_y,
   input  logic signed [scc_pkg::POS_W-1:0]     req_second_pos_x,
   input  logic signed [scc_pkg::POS_W-1:0]     req_second_pos_y,
   input  logic signed [scc_pkg::VEL_W-1:0]     req_second_vel_x,
   input  logic signed [scc_pkg::VEL_W-1:0]     req_second_vel_y,
   output logic                                 rsp_valid,
   output logic                                 rsp_hit,
   output logic [TIME_FRAC_BITS:0]              rsp_hit_time,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [scc_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [scc_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [scc_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);
   import scc_pkg::*;

   logic [D2_W-1:0]                d2;
   logic                           req_valid;
   scc_job_type                    geom_job, sqrt_job;
   logic [D_W-1:0]                 disc;
   logic [D_W/2+TIME_FRAC_BITS-1:0] root;
   logic                           rem_nz;

   // The pipeline never stalls, so every start is taken.
   assign busy      = 1'b0;
   assign pready    = 1'b1;
   assign req_valid = start & ~busy;

   scc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .d2      (d2)
   );

   scc_geom u_geom (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .first_pos_x  (req_first_pos_x),
      .first_pos_y  (req_first_pos_y),
      .first_vel_x  (req_first_vel_x),
      .first_vel_y  (req_first_vel_y),
      .second_pos_x (req_second_pos_x),
      .second_pos_y (req_second_pos_y),
      .second_vel_x (req_second_vel_x),
      .second_vel_y (req_second_vel_y),
      .d2           (d2),
      .job          (geom_job),
      .disc         (disc)
   );

   scc_sqrt #(
      .FRAC (TIME_FRAC_BITS)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .job_i    (geom_job),
      .disc_i   (disc),
      .job_o    (sqrt_job),
      .root_o   (root),
      .rem_nz_o (rem_nz)
   );

   scc_div #(
      .FRAC (TIME_FRAC_BITS)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .job_i        (sqrt_job),
      .root_i       (root),
      .rem_nz_i     (rem_nz),
      .rsp_valid    (rsp_valid),
      .rsp_hit      (rsp_hit),
      .rsp_hit_time (rsp_hit_time)
   );

endmodule

[tb/sv/scc_checker.sv]
`timescale 1ns / 1ps

module scc_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic signed [scc_pkg::POS_W-1:0]  first_pos_x,
   input  logic signed [scc_pkg::POS_W-1:0]  first_pos_y,
   input  logic signed [scc_pkg::VEL_W-1:0]  first_vel_x,
   input  logic signed [scc_pkg::VEL_W-1:0]  first_vel_y,
   input  logic signed [scc_pkg::POS_W-1:0]  second_pos_x,
   input  logic signed [scc_pkg::POS_W-1:0]  second_pos_y,
   input  logic signed [scc_pkg::VEL_W-1:0]  second_vel_x,
   input  logic signed [scc_pkg::VEL_W-1:0]  second_vel_y,
   input  logic                              rsp_valid,
   input  logic                              rsp_hit,
   input  logic [16:0]                       rsp_hit_time,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [scc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [scc_pkg::CSR_DATA_W-1:0]    pwdata,
   input  logic                              pready,
   output int                                error_count,
   output int                                pending_count,
   output int                                hit_count,
   output int                                result_count
);
   import scc_pkg::*;

   localparam int FRAC = 16;
   localparam logic [CSR_ADDR_W-1:0] ADDR_RADIUS = 3'd0;

   typedef struct {
      bit          hit;
      logic [16:0] hit_time;
   } contact_type;

   contact_type           expected_contacts[$];
   logic [RAD_W-1:0]      radius;

   // Exact test of t*(a + sqrt(d)) <= m using wide products.
   function automatic bit time_fits(longint unsigned t, longint unsigned a,
                                    longint unsigned d, longint unsigned m);
      logic [127:0] lhs;
      logic [127:0] rhs;
      longint unsigned e;
      if (t * a > m)
         return 0;
      e   = m - t * a;
      lhs = 128'(t * t) * 128'(d);
      rhs = 128'(e) * 128'(e);
      return lhs <= rhs;
   endfunction

   // Earliest contact of the second circle relative to the first.
   function automatic contact_type predict_contact(
         longint fpx, longint fpy, longint fvx, longint fvy,
         longint spx, longint spy, longint svx, longint svy, longint rad);
      contact_type r;
      longint px, py, vx, vy, w, pv, cr, acr, d2, lim, pp, c, d, ex, ey;
      longint unsigned a, m, lo, hi, mid;
      bit near;
      r.hit = 0;
      r.hit_time = '0;
      px = spx - fpx;
      py = spy - fpy;
      vx = svx - fvx;
      vy = svy - fvy;
      w  = vx * vx + vy * vy;
      if (w == 0)
         return r;
      pv  = px * vx + py * vy;
      cr  = px * vy - py * vx;
      acr = cr < 0 ? -cr : cr;
      if (acr >= (64'sd1 <<< 27))
         return r;
      d2  = (2 * rad) * (2 * rad);
      lim = d2 * w;
      // Nearest point of the path: the end, the start, or the interior.
      if (pv + w < 0) begin
         ex = px + vx;
         ey = py + vy;
         near = ex * ex + ey * ey <= d2;
      end else if (pv > 0) begin
         near = px * px + py * py <= d2;
      end else begin
         near = acr * acr <= lim;
      end
      if (!near)
         return r;
      pp = px * px + py * py;
      if (pp < d2) begin
         r.hit = (pv < 0);
         return r;
      end
      c = pp - d2;
      r.hit = 1;
      if (c == 0)
         return r;
      d = lim - acr * acr;
      if (d < 0)
         d = 0;
      a  = pv < 0 ? -pv : pv;
      m  = longint'(c) << FRAC;
      lo = 0;
      hi = 64'd1 << FRAC;
      // Largest time step that still fits, by bisection.
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         if (time_fits(mid, a, d, m))
            lo = mid;
         else
            hi = mid - 1;
      end
      r.hit_time = lo[16:0];
      return r;
   endfunction

   // Track the radius register, predict each request and check each result.
   always @(posedge clock) begin
      contact_type exp_c;
      if (reset) begin
         radius <= RADIUS_RESET;
         expected_contacts.delete();
         error_count   <= 0;
         hit_count     <= 0;
         result_count  <= 0;
         pending_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == ADDR_RADIUS)
            radius <= pwdata[RAD_W-1:0];
         if (start && !busy)
            expected_contacts.insert(expected_contacts.size(), predict_contact(
               first_pos_x, first_pos_y, first_vel_x, first_vel_y,
               second_pos_x, second_pos_y, second_vel_x, second_vel_y,
               longint'(radius)));
         if (rsp_valid) begin
            result_count <= result_count + 1;
            if (rsp_hit)
               hit_count <= hit_count + 1;
            if (expected_contacts.size() == 0) begin
               if (error_count < 10)
                  $display("ERROR: result with no request pending (hit=%0d time=%0d)",
                           rsp_hit, rsp_hit_time);
               error_count <= error_count + 1;
            end else begin
               exp_c = expected_contacts.pop_front();
               if (exp_c.hit !== rsp_hit || exp_c.hit_time !== rsp_hit_time) begin
                  if (error_count < 10)
                     $display("ERROR: hit expected %0d got %0d, time expected %0d got %0d",
                              exp_c.hit, rsp_hit, exp_c.hit_time, rsp_hit_time);
                  error_count <= error_count + 1;
               end
            end
         end
         pending_count <= expected_contacts.size();
      end
   end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import scc_pkg::*;

   localparam int LATENCY = 67;
   localparam logic [CSR_ADDR_W-1:0] ADDR_RADIUS = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE  = 3'd4;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [POS_W-1:0] fpx, fpy, spx, spy;
   logic signed [VEL_W-1:0] fvx, fvy, svx, svy;
   logic rsp_valid;
   logic rsp_hit;
   logic [16:0] rsp_hit_time;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;
   int error_count, pending_count, hit_count, result_count;
   int idle_pct;
   int radius_now;
   int sent;

   swept_circle_collision_time_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_first_pos_x(fpx), .req_first_pos_y(fpy),
      .req_first_vel_x(fvx), .req_first_vel_y(fvy),
      .req_second_pos_x(spx), .req_second_pos_y(spy),
      .req_second_vel_x(svx), .req_second_vel_y(svy),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_hit_time(rsp_hit_time),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   scc_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .first_pos_x(fpx), .first_pos_y(fpy), .first_vel_x(fvx), .first_vel_y(fvy),
      .second_pos_x(spx), .second_pos_y(spy), .second_vel_x(svx), .second_vel_y(svy),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_hit_time(rsp_hit_time),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .error_count(error_count), .pending_count(pending_count),
      .hit_count(hit_count), .result_count(result_count)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int clamp(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Present one request, with random idle cycles in front of it.
   task automatic send_request(int a, int b, int c, int d, int e, int f, int g, int h);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start = 0;
         @(negedge clock);
      end
      fpx = POS_W'(a); fpy = POS_W'(b); fvx = VEL_W'(c); fvy = VEL_W'(d);
      spx = POS_W'(e); spy = POS_W'(f); svx = VEL_W'(g); svy = VEL_W'(h);
      start = 1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      sent++;
   endtask

   // Two-phase register write.
   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      start = 0;
      psel = 1; pwrite = 1; penable = 0; paddr = addr; pwdata = data;
      @(negedge clock);
      penable = 1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
   endtask

   // Hold off until every request has come back, then let the pipe empty.
   task automatic drain();
      @(negedge clock);
      start = 0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // Random requests, most of them on a course close to contact.
   task automatic random_requests(int count);
      int reach, span, ox, oy, rvx, rvy, ax, ay, avx, avy, kind;
      reach = 2 * radius_now;
      span = 2 * reach + 64;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(99);
         if (kind < 65) begin
            ax  = $urandom_range(240000) - 120000;
            ay  = $urandom_range(240000) - 120000;
            avx = $urandom_range(8190) - 4095;
            avy = $urandom_range(8190) - 4095;
            ox  = $urandom_range(2 * span) - span;
            oy  = $urandom_range(2 * span) - span;
            rvx = clamp(-ox + int'($urandom_range(2 * reach + 2)) - reach - 1, -4095, 4095);
            rvy = clamp(-oy + int'($urandom_range(2 * reach + 2)) - reach - 1, -4095, 4095);
            if (kind < 5) begin
               rvx = 0;
               rvy = 0;
            end
            send_request(ax, ay, avx, avy, ax + ox, ay + oy, avx + rvx, avy + rvy);
         end else if (kind < 85) begin
            send_request($urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
         end else begin
            send_request($urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
                         $urandom_range(2000) - 1000, $urandom_range(2000) - 1000,
                         $urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
                         $urandom_range(2000) - 1000, $urandom_range(2000) - 1000);
         end
      end
   endtask

   initial begin
      reset = 1; start = 0; sent = 0;
      fpx = 0; fpy = 0; fvx = 0; fvy = 0; spx = 0; spy = 0; svx = 0; svy = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      idle_pct = 25;
      radius_now = 400;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed cases at the reset radius (contact distance 800).
      send_request(0, 0, 0, 0, 0, 0, 0, 0);
      send_request(-131072, -131072, -8192, -8192, 131071, 131071, 8191, 8191);
      send_request(131071, 131071, 8191, 8191, -131072, -131072, -8192, -8192);
      send_request(0, 0, 0, 0, 100, 0, -50, 0);
      send_request(0, 0, 0, 0, 100, 0, 50, 0);
      send_request(0, 0, 0, 0, 100, 0, 0, 50);
      send_request(0, 0, 0, 0, 800, 0, -10, 0);
      send_request(0, 0, 0, 0, 800, 0, 10, 0);
      send_request(0, 0, 0, 0, 1600, 0, -1600, 0);
      send_request(0, 0, 0, 0, 1800, 0, -1000, 0);
      send_request(0, 0, 0, 0, 1801, 0, -1000, 0);
      send_request(0, 0, 0, 0, 1799, 0, -1000, 0);
      send_request(0, 0, 0, 0, -500, 800, 1000, 0);
      send_request(0, 0, 0, 0, -500, 801, 1000, 0);
      send_request(0, 0, -8192, 0, -5000, 0, 8191, 0);
      send_request(-131072, 0, 0, 0, 131071, 0, 0, 8191);
      send_request(5, 5, 300, -300, 15, 15, 300, -300);
      send_request(0, 0, 0, 0, 1000, 1000, -900, -900);
      send_request(0, 0, 0, 0, 801, 0, -1, 0);
      send_request(-131072, 131071, 8191, -8192, -131072, 131071, -8192, 8191);
      random_requests(160);
      drain();

      // Next settings: smallest nonzero radius, sender mostly idle.
      csr_write(ADDR_RADIUS, 32'd1);
      csr_write(ADDR_SPARE, 32'hffff_ffff);
      radius_now = 1;
      idle_pct = 79;
      send_request(0, 0, 0, 0, 2, 0, -1, 0);
      send_request(0, 0, 0, 0, 3, 0, -8, 0);
      random_requests(160);
      drain();

      // Largest radius, no idling.
      csr_write(ADDR_RADIUS, 32'hffff_f7ff);
      radius_now = 2047;
      idle_pct = 0;
      random_requests(160);
      drain();

      // Zero radius: touching only when the path meets the other centre.
      csr_write(ADDR_RADIUS, 32'd0);
      radius_now = 0;
      idle_pct = 25;
      send_request(0, 0, 0, 0, 10, 0, -20, 0);
      send_request(0, 0, 0, 0, 10, 0, -5, 0);
      random_requests(160);
      drain();

      // A random radius to finish.
      radius_now = $urandom_range(2047, 1);
      csr_write(ADDR_RADIUS, radius_now);
      idle_pct = 0;
      random_requests(160);

      @(negedge clock);
      start = 0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);

      $display("Sent %0d requests over five radius settings (1, 400, 2047, 0, random).",
               sent);
      $display("Checked %0d results, %0d of them contacts; %0d mismatches.",
               result_count, hit_count, error_count);
      if (error_count == 0 && pending_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
